// ===== design/pid_controller_step_top_macros.svh =====
// ----------------------------------------------------------------------------
// PID controller step assertion macros
// Assertion helpers shared by the controller RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_TOP_MACROS_SVH
`define PID_CONTROLLER_STEP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_IMPLIES(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("pidc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("pidc assertion failed");

`else

`define PIDC_ASSERT_IMPLIES(label, ck, rn, pre, post)
`define PIDC_ASSERT_NEXT(label, ck, rn, pre, post)

`endif

`endif

// ===== design/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;

    // Configuration register widths.
    localparam int COEF_W     = 16;
    localparam int OLIM_W     = 15;
    localparam int ILIM_W     = 20;
    localparam int DBAND_W    = 16;
    localparam int GATE_W     = 17;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths.
    localparam int ERR_W   = DATA_WIDTH + 1;
    localparam int DIFF_W  = DATA_WIDTH + 2;
    localparam int INT_W   = ILIM_W + 3;
    localparam int ISUM_W  = ((INT_W > ERR_W + 1) ? INT_W : ERR_W + 1) + 1;
    localparam int MAG_W   = (ERR_W > GATE_W) ? ERR_W : GATE_W;
    localparam int P_W     = COEF_W + ERR_W;
    localparam int I_W     = COEF_W + INT_W;
    localparam int D_W     = COEF_W + DIFF_W;
    localparam int PD_MAX  = (P_W > D_W) ? P_W + 1 : D_W + 1;
    localparam int SUM_W   = ((PD_MAX > I_W) ? PD_MAX : I_W) + 2;

    // Reset values of the limit registers.
    localparam logic [OLIM_W-1:0] OLIM_RESET = 15'h7fff;
    localparam logic [ILIM_W-1:0] ILIM_RESET = 20'hfffff;
    localparam logic [GATE_W-1:0] GATE_RESET = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_OUT_LIMIT      = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_DEAD_BAND      = 3'd5,
        REG_ERROR_GATE     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] gain_p;
        logic signed [COEF_W-1:0] gain_i;
        logic signed [COEF_W-1:0] gain_d;
        logic [OLIM_W-1:0]        out_limit;
        logic [ILIM_W-1:0]        integral_limit;
        logic [DBAND_W-1:0]       dead_band;
        logic [GATE_W-1:0]        error_gate;
    } cfg_t;

    // Stage enables from the pipeline control in the top level.
    typedef struct packed {
        logic en_b;
        logic load_b;
        logic en_c;
        logic en_d;
    } pipe_ctrl_t;

    // Results of the state update, carried to the multiply stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [INT_W-1:0]  integ;
        logic                     clear;
        logic                     dead;
    } upd_t;

endpackage

// ===== design/pid_controller_step_top.sv =====
// ----------------------------------------------------------------------------
// PID controller step
// Positional PID with dead band, gated trapezoidal integral and output clamp.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless sample_stall is raised.
// The item passes four registers: the input register, loaded at acceptance,
// the state update stage, the gain multiply stage and the output register.
// The rate is set by the state loop, which forms the error, checks the dead
// band and error gate, and adds and clamps the integral ahead of the state
// registers so that the next item sees the updated last error, integral and
// setpoint. The multiplies and the rounding and saturation follow in later
// stages outside that loop. Each stage moves when it is empty or when the
// stage after it moves, so a stalled result does not stop the block from
// taking items until every stage is full. Configuration registers are
// written through a separate channel that is always ready; write them only
// while no item is in flight.
// ----------------------------------------------------------------------------
`include "pid_controller_step_top_macros.svh"

module pid_controller_step_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    // Configuration channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]         cfg_data,

    // Sample channel.
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [pidc_pkg::DATA_WIDTH-1:0]  measured,
    input  logic signed [pidc_pkg::DATA_WIDTH-1:0]  target,
    input  logic                                    hold_target,
    input  logic                                    clear_state,

    // Result channel.
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [pidc_pkg::DATA_WIDTH-1:0]  drive,
    output logic                                    saturated,
    output logic                                    in_dead_band
);

    localparam int DW = pidc_pkg::DATA_WIDTH;

    pidc_pkg::cfg_t       cfg;
    pidc_pkg::pipe_ctrl_t ctrl;
    pidc_pkg::upd_t       upd;

    logic a_valid_reg;
    logic a_valid_next;
    logic b_valid_reg;
    logic b_valid_next;
    logic c_valid_reg;
    logic c_valid_next;
    logic d_valid_reg;
    logic d_valid_next;
    logic en_a;

    logic signed [DW-1:0] a_measured_reg;
    logic signed [DW-1:0] a_target_reg;
    logic                 a_hold_reg;
    logic                 a_clear_reg;

    // The configuration channel never needs to wait.
    assign cfg_ready = 1'b1;

    pidc_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // A stage advances when it holds nothing or the stage after it advances.
    always_comb
    begin
        ctrl.en_d   = !d_valid_reg || !result_stall;
        ctrl.en_c   = !c_valid_reg || ctrl.en_d;
        ctrl.en_b   = !b_valid_reg || ctrl.en_c;
        ctrl.load_b = ctrl.en_b && a_valid_reg;
        en_a        = !a_valid_reg || ctrl.en_b;

        a_valid_next = en_a      ? sample_valid : a_valid_reg;
        b_valid_next = ctrl.en_b ? a_valid_reg  : b_valid_reg;
        c_valid_next = ctrl.en_c ? b_valid_reg  : c_valid_reg;
        d_valid_next = ctrl.en_d ? c_valid_reg  : d_valid_reg;
    end

    assign sample_stall = !en_a;
    assign result_valid = d_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    // Input register; the item is captured whenever the first stage is free.
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_measured_reg <= measured;
            a_target_reg   <= target;
            a_hold_reg     <= hold_target;
            a_clear_reg    <= clear_state;
        end
    end

    pidc_update u_update
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (cfg),
        .a_measured (a_measured_reg),
        .a_target   (a_target_reg),
        .a_hold     (a_hold_reg),
        .a_clear    (a_clear_reg),
        .upd        (upd)
    );

    pidc_output u_output
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .upd          (upd),
        .drive        (drive),
        .saturated    (saturated),
        .in_dead_band (in_dead_band)
    );

    // The sample side waits only when every stage holds an item and the
    // result is being held off.
    `PIDC_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, sample_stall, a_valid_reg && b_valid_reg && c_valid_reg && d_valid_reg && result_stall)

endmodule

// ===== design/pidc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// PID controller configuration registers
// Holds gains and limits, written through the configuration channel.
// ----------------------------------------------------------------------------
module pidc_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]     wr_data,
    output pidc_pkg::cfg_t                      cfg
);

    pidc_pkg::cfg_t cfg_reg;
    pidc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                pidc_pkg::REG_GAIN_P:
                    cfg_next.gain_p = wr_data[pidc_pkg::COEF_W-1:0];
                pidc_pkg::REG_GAIN_I:
                    cfg_next.gain_i = wr_data[pidc_pkg::COEF_W-1:0];
                pidc_pkg::REG_GAIN_D:
                    cfg_next.gain_d = wr_data[pidc_pkg::COEF_W-1:0];
                pidc_pkg::REG_OUT_LIMIT:
                    cfg_next.out_limit = wr_data[pidc_pkg::OLIM_W-1:0];
                pidc_pkg::REG_INTEGRAL_LIMIT:
                    cfg_next.integral_limit = wr_data[pidc_pkg::ILIM_W-1:0];
                pidc_pkg::REG_DEAD_BAND:
                    cfg_next.dead_band = wr_data[pidc_pkg::DBAND_W-1:0];
                pidc_pkg::REG_ERROR_GATE:
                    cfg_next.error_gate = wr_data[pidc_pkg::GATE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.out_limit      <= pidc_pkg::OLIM_RESET;
            cfg_reg.integral_limit <= pidc_pkg::ILIM_RESET;
            cfg_reg.dead_band      <= '0;
            cfg_reg.error_gate     <= pidc_pkg::GATE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pidc_update.sv =====
// ----------------------------------------------------------------------------
// PID controller state update
// Forms the error, applies dead band, integrates and clamps, holds the state.
// ----------------------------------------------------------------------------
`include "pid_controller_step_top_macros.svh"

module pidc_update
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pidc_pkg::pipe_ctrl_t                   ctrl,
    input  pidc_pkg::cfg_t                         cfg,
    input  logic signed [pidc_pkg::DATA_WIDTH-1:0] a_measured,
    input  logic signed [pidc_pkg::DATA_WIDTH-1:0] a_target,
    input  logic                                   a_hold,
    input  logic                                   a_clear,
    output pidc_pkg::upd_t                         upd
);

    localparam int DW = pidc_pkg::DATA_WIDTH;
    localparam int EW = pidc_pkg::ERR_W;
    localparam int FW = pidc_pkg::DIFF_W;
    localparam int IW = pidc_pkg::INT_W;
    localparam int SW = pidc_pkg::ISUM_W;
    localparam int MW = pidc_pkg::MAG_W;

    logic signed [DW-1:0] stored_target_reg;
    logic signed [DW-1:0] stored_target_next;
    logic signed [EW-1:0] prev_err_reg;
    logic signed [EW-1:0] prev_err_next;
    logic signed [IW-1:0] integ_reg;
    logic signed [IW-1:0] integ_next;
    pidc_pkg::upd_t       upd_reg;
    pidc_pkg::upd_t       upd_next;

    logic signed [DW-1:0] setpoint;
    logic signed [EW-1:0] err;
    logic [EW-1:0]        err_mag;
    logic [MW-1:0]        mag_ext;
    logic                 dead;
    logic                 gate_open;
    logic signed [FW-1:0] diff;
    logic signed [SW-1:0] isum;
    logic signed [SW-1:0] ilim_pos;
    logic signed [SW-1:0] ilim_neg;
    logic signed [SW-1:0] iclamped;

    always_comb
    begin
        setpoint  = a_hold ? stored_target_reg : a_target;
        err       = EW'(setpoint) - EW'(a_measured);
        err_mag   = err[EW-1] ? EW'(-err) : EW'(err);
        mag_ext   = MW'(err_mag);
        dead      = mag_ext < MW'(cfg.dead_band);
        gate_open = mag_ext < MW'(cfg.error_gate);
        diff      = FW'(err) - FW'(prev_err_reg);

        // Trapezoid in half units: the sum of this and the last error.
        isum = SW'(integ_reg);
        if (gate_open)
        begin
            isum = isum + SW'(err) + SW'(prev_err_reg);
        end

        ilim_pos = SW'({cfg.integral_limit, 1'b0});
        ilim_neg = -ilim_pos;
        if (isum >= ilim_pos)
        begin
            iclamped = ilim_pos;
        end
        else if (isum <= ilim_neg)
        begin
            iclamped = ilim_neg;
        end
        else
        begin
            iclamped = isum;
        end

        stored_target_next = stored_target_reg;
        prev_err_next      = prev_err_reg;
        integ_next         = integ_reg;
        if (ctrl.load_b)
        begin
            if (a_clear)
            begin
                stored_target_next = '0;
                prev_err_next      = '0;
                integ_next         = '0;
            end
            else
            begin
                stored_target_next = setpoint;
                if (!dead)
                begin
                    prev_err_next = err;
                    integ_next    = iclamped[IW-1:0];
                end
            end
        end

        upd_next       = upd_reg;
        if (ctrl.en_b)
        begin
            upd_next.err   = err;
            upd_next.diff  = diff;
            upd_next.integ = iclamped[IW-1:0];
            upd_next.clear = a_clear;
            upd_next.dead  = dead;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_target_reg <= '0;
            prev_err_reg      <= '0;
            integ_reg         <= '0;
        end
        else
        begin
            stored_target_reg <= stored_target_next;
            prev_err_reg      <= prev_err_next;
            integ_reg         <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_reg <= upd_next;
    end

    assign upd = upd_reg;

    `PIDC_ASSERT_NEXT(a_clear_zeroes_state, clk, rst_n, ctrl.load_b && a_clear, (stored_target_reg == '0) && (prev_err_reg == '0) && (integ_reg == '0))

endmodule

// ===== design/pidc_output.sv =====
// ----------------------------------------------------------------------------
// PID controller output stages
// Weights the terms with the gains, rounds, saturates and registers the item.
// ----------------------------------------------------------------------------
`include "pid_controller_step_top_macros.svh"

module pidc_output
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pidc_pkg::pipe_ctrl_t                    ctrl,
    input  pidc_pkg::cfg_t                          cfg,
    input  pidc_pkg::upd_t                          upd,
    output logic signed [pidc_pkg::DATA_WIDTH-1:0]  drive,
    output logic                                    saturated,
    output logic                                    in_dead_band
);

    localparam int DW  = pidc_pkg::DATA_WIDTH;
    localparam int PW  = pidc_pkg::P_W;
    localparam int IPW = pidc_pkg::I_W;
    localparam int DPW = pidc_pkg::D_W;
    localparam int SW  = pidc_pkg::SUM_W;
    localparam int FB  = pidc_pkg::GAIN_FRAC_BITS;
    localparam logic signed [SW-1:0] ROUND = SW'(1) << FB;

    // Multiply stage.
    logic signed [PW-1:0]  p_prod_reg;
    logic signed [IPW-1:0] i_prod_reg;
    logic signed [DPW-1:0] d_prod_reg;
    logic                  c_clear_reg;
    logic                  c_dead_reg;

    // Result stage.
    logic signed [DW-1:0]  drive_reg;
    logic signed [DW-1:0]  drive_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic                  dead_reg;
    logic                  dead_next;

    logic signed [SW-1:0]  sum;
    logic signed [SW-1:0]  rounded;
    logic signed [SW-1:0]  lim_pos;
    logic signed [SW-1:0]  lim_neg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en_c)
        begin
            p_prod_reg  <= PW'(cfg.gain_p) * PW'(upd.err);
            i_prod_reg  <= IPW'(cfg.gain_i) * IPW'(upd.integ);
            d_prod_reg  <= DPW'(cfg.gain_d) * DPW'(upd.diff);
            c_clear_reg <= upd.clear;
            c_dead_reg  <= upd.dead;
        end
    end

    always_comb
    begin
        // Weighted sum carries one more fraction bit than the gains.
        sum     = (SW'(p_prod_reg) <<< 1) + SW'(i_prod_reg)
                  + (SW'(d_prod_reg) <<< 1) + ROUND;
        rounded = sum >>> (FB + 1);
        lim_pos = SW'({1'b0, cfg.out_limit});
        lim_neg = -lim_pos;

        drive_next = rounded[DW-1:0];
        sat_next   = 1'b0;
        dead_next  = 1'b0;
        if (c_clear_reg)
        begin
            drive_next = '0;
        end
        else if (c_dead_reg)
        begin
            drive_next = '0;
            dead_next  = 1'b1;
        end
        else if (rounded > lim_pos)
        begin
            drive_next = lim_pos[DW-1:0];
            sat_next   = 1'b1;
        end
        else if (rounded < lim_neg)
        begin
            drive_next = lim_neg[DW-1:0];
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_d)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
            dead_reg  <= dead_next;
        end
    end

    assign drive        = drive_reg;
    assign saturated    = sat_reg;
    assign in_dead_band = dead_reg;

    `PIDC_ASSERT_NEXT(a_clear_gives_zero, clk, rst_n, ctrl.en_d && c_clear_reg, (drive_reg == '0) && !sat_reg && !dead_reg)
    `PIDC_ASSERT_NEXT(a_dead_band_gives_zero, clk, rst_n, ctrl.en_d && c_dead_reg && !c_clear_reg, (drive_reg == '0) && !sat_reg && dead_reg)

endmodule
